// ----- sv/slfp_pkg.sv -----
// ============================================================================
// slfp_pkg
// Shared types, constants and the crc-8 byte update for the sync/length frame
// parser.
// ============================================================================
package slfp_pkg;

    localparam int DATA_W     = 8;
    localparam int LEN_W      = 7;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int HDR_LEN_W  = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT = 2'd2;

    localparam logic [DATA_W-1:0] SYNC_FIRST_RST   = 8'hAA;
    localparam logic [DATA_W-1:0] SYNC_SECOND_RST  = 8'h55;
    localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RST = 7'd64;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_GOOD    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LEN_ERR = 2'd2;

    localparam logic [DATA_W-1:0] CRC_POLY = 8'h07;
    localparam logic [DATA_W-1:0] CRC_MSB  = 8'h80;

    typedef struct packed {
        logic [DATA_W-1:0] rx_byte;
    } rx_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   frame_type;
        logic [LEN_W-1:0]    frame_length;
        logic [DATA_W-1:0]   payload_byte;
        logic [IDX_W-1:0]    byte_index;
        logic                last;
        logic [CNT_W-1:0]    resync_count;
    } res_t;

    typedef enum logic [3:0] {
        ST_SYNC_A,
        ST_SYNC_B,
        ST_TYPE,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_BODY,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    typedef enum logic [1:0] {
        RES_DATA,
        RES_EMPTY,
        RES_CRC_ERR,
        RES_LEN_ERR
    } res_kind_t;

    typedef struct packed {
        logic      ld_type;
        logic      ld_len_lo;
        logic      ld_len_hi;
        logic      crc_upd;
        logic      wr_body;
        logic      rd_clr;
        logic      rd_inc;
        logic      cnt_inc;
        logic      out_load;
        res_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic is_first;
        logic is_second;
        logic len_over;
        logic len_zero;
        logic body_last;
        logic crc_ok;
        logic len_empty;
        logic emit_last;
        logic out_free;
    } sts_t;

    // msb-first crc-8 over one byte
    function automatic logic [DATA_W-1:0] crc_byte(input logic [DATA_W-1:0] crc,
                                                   input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] v;
        v = crc ^ b;
        for (int i = 0; i < DATA_W; i++)
        begin
            if ((v & CRC_MSB) != '0)
            begin
                v = (v << 1) ^ CRC_POLY;
            end
            else
            begin
                v = v << 1;
            end
        end
        return v;
    endfunction

endpackage

// ----- sv/slfp_stream_if.sv -----
// ============================================================================
// slfp_stream_if
// Valid/ready channel carrying one payload struct per request.
// ============================================================================
interface slfp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/slfp_datapath.sv -----
// ============================================================================
// slfp_datapath
// Configuration registers, header/crc registers, payload memory, reject
// counter and the output register.
// ============================================================================
module slfp_datapath #(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [slfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slfp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [slfp_pkg::DATA_W-1:0]     rx_byte,
    input  slfp_pkg::cmd_t                  cmd,
    output slfp_pkg::sts_t                  sts,
    output logic                            out_valid,
    input  logic                            out_ready,
    output slfp_pkg::res_t                  out_payload
);
    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam logic [slfp_pkg::LEN_W-1:0] DEPTH_LEN = slfp_pkg::LEN_W'(PAYLOAD_DEPTH);

    logic [slfp_pkg::DATA_W-1:0] sync_first_reg, sync_second_reg;
    logic [slfp_pkg::LEN_W-1:0]  limit_reg;
    logic [slfp_pkg::DATA_W-1:0] type_reg, len_lo_reg, crc_reg, crc_next;
    logic [slfp_pkg::LEN_W-1:0]  len_reg, fill_reg, rd_idx_reg;
    logic [slfp_pkg::DATA_W-1:0] rd_data_reg;
    logic [slfp_pkg::CNT_W-1:0]  reject_reg, reject_next;
    logic                        out_valid_reg;
    slfp_pkg::res_t              out_reg, out_next;
    logic [slfp_pkg::DATA_W-1:0] mem [PAYLOAD_DEPTH];

    logic [slfp_pkg::LEN_W-1:0]     lim;
    logic [slfp_pkg::HDR_LEN_W-1:0] hdr_len;
    logic                           out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= slfp_pkg::SYNC_FIRST_RST;
            sync_second_reg <= slfp_pkg::SYNC_SECOND_RST;
            limit_reg       <= slfp_pkg::LENGTH_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                slfp_pkg::CFG_SYNC_FIRST:   sync_first_reg  <= cfg_data;
                slfp_pkg::CFG_SYNC_SECOND:  sync_second_reg <= cfg_data;
                slfp_pkg::CFG_LENGTH_LIMIT: limit_reg       <= cfg_data[slfp_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign lim      = (limit_reg > DEPTH_LEN) ? DEPTH_LEN : limit_reg;
    assign hdr_len  = {rx_byte, len_lo_reg};
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        sts.is_first  = (rx_byte == sync_first_reg);
        sts.is_second = (rx_byte == sync_second_reg);
        sts.len_over  = (hdr_len > slfp_pkg::HDR_LEN_W'(lim));
        sts.len_zero  = (hdr_len == '0);
        sts.body_last = ({1'b0, fill_reg} + 8'd1) >= {1'b0, len_reg};
        sts.crc_ok    = (crc_reg == rx_byte);
        sts.len_empty = (len_reg == '0);
        sts.emit_last = ({1'b0, rd_idx_reg} + 8'd1) == {1'b0, len_reg};
        sts.out_free  = out_free;
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (cmd.ld_type)
        begin
            crc_next = slfp_pkg::crc_byte('0, rx_byte);
        end
        else if (cmd.crc_upd)
        begin
            crc_next = slfp_pkg::crc_byte(crc_reg, rx_byte);
        end
    end

    assign reject_next = cmd.cnt_inc ? reject_reg + 1'b1 : reject_reg;

    always_comb
    begin
        out_next              = '0;
        out_next.frame_type   = type_reg;
        out_next.last         = 1'b1;
        out_next.resync_count = reject_next;
        case (cmd.kind)
            slfp_pkg::RES_DATA:
            begin
                out_next.status       = slfp_pkg::STATUS_GOOD;
                out_next.frame_length = len_reg;
                out_next.payload_byte = rd_data_reg;
                out_next.byte_index   = rd_idx_reg[slfp_pkg::IDX_W-1:0];
                out_next.last         = sts.emit_last;
            end
            slfp_pkg::RES_EMPTY:   out_next.status = slfp_pkg::STATUS_GOOD;
            slfp_pkg::RES_CRC_ERR: out_next.status = slfp_pkg::STATUS_CRC_ERR;
            slfp_pkg::RES_LEN_ERR: out_next.status = slfp_pkg::STATUS_LEN_ERR;
            default:               out_next.status = slfp_pkg::STATUS_GOOD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            type_reg      <= '0;
            len_lo_reg    <= '0;
            len_reg       <= '0;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            reject_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg    <= crc_next;
            reject_reg <= reject_next;
            if (cmd.ld_type)
            begin
                type_reg <= rx_byte;
            end
            if (cmd.ld_len_lo)
            begin
                len_lo_reg <= rx_byte;
            end
            if (cmd.ld_len_hi)
            begin
                // header length already checked against the limit
                len_reg  <= hdr_len[slfp_pkg::LEN_W-1:0];
                fill_reg <= '0;
            end
            else if (cmd.wr_body)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.rd_clr)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.rd_inc)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    // payload memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_body)
        begin
            mem[fill_reg[AW-1:0]] <= rx_byte;
        end
        rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
    end

    assign out_valid   = out_valid_reg;
    assign out_payload = out_reg;

endmodule

// ----- sv/slfp_ctrl.sv -----
// ============================================================================
// slfp_ctrl
// Frame state machine: sync hunt, header, body, crc check and burst readout.
// ============================================================================
module slfp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  slfp_pkg::sts_t sts,
    output slfp_pkg::cmd_t cmd
);
    slfp_pkg::state_t state_reg, state_next;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slfp_pkg::ST_SYNC_A;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cmd.kind = slfp_pkg::RES_DATA;
        case (state_reg)
            slfp_pkg::ST_SYNC_A, slfp_pkg::ST_SYNC_B, slfp_pkg::ST_TYPE,
            slfp_pkg::ST_LEN_LO, slfp_pkg::ST_BODY:
                in_ready = 1'b1;
            // these phases may post a result and need the output slot
            slfp_pkg::ST_LEN_HI, slfp_pkg::ST_CHECK:
                in_ready = sts.out_free;
            default:
                in_ready = 1'b0;
        endcase
        accept = in_valid && in_ready;

        case (state_reg)
            slfp_pkg::ST_TYPE:
                cmd.ld_type = accept;
            slfp_pkg::ST_LEN_LO:
            begin
                cmd.ld_len_lo = accept;
                cmd.crc_upd   = accept;
            end
            slfp_pkg::ST_LEN_HI:
            begin
                cmd.crc_upd = accept;
                if (sts.len_over)
                begin
                    cmd.out_load = accept;
                    cmd.cnt_inc  = accept;
                    cmd.kind     = slfp_pkg::RES_LEN_ERR;
                end
                else
                begin
                    cmd.ld_len_hi = accept;
                end
            end
            slfp_pkg::ST_BODY:
            begin
                cmd.wr_body = accept;
                cmd.crc_upd = accept;
            end
            slfp_pkg::ST_CHECK:
            begin
                if (!sts.crc_ok)
                begin
                    cmd.out_load = accept;
                    cmd.cnt_inc  = accept;
                    cmd.kind     = slfp_pkg::RES_CRC_ERR;
                end
                else if (sts.len_empty)
                begin
                    cmd.out_load = accept;
                    cmd.kind     = slfp_pkg::RES_EMPTY;
                end
                else
                begin
                    cmd.rd_clr = accept;
                end
            end
            slfp_pkg::ST_EMIT_WR:
            begin
                cmd.out_load = sts.out_free;
                cmd.rd_inc   = sts.out_free;
                cmd.kind     = slfp_pkg::RES_DATA;
            end
            default: ;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slfp_pkg::ST_SYNC_A:
                if (accept && sts.is_first)
                begin
                    state_next = slfp_pkg::ST_SYNC_B;
                end
            slfp_pkg::ST_SYNC_B:
                if (accept)
                begin
                    // second sync wins; a repeated first sync keeps waiting
                    if (sts.is_second)
                    begin
                        state_next = slfp_pkg::ST_TYPE;
                    end
                    else if (!sts.is_first)
                    begin
                        state_next = slfp_pkg::ST_SYNC_A;
                    end
                end
            slfp_pkg::ST_TYPE:
                if (accept)
                begin
                    state_next = slfp_pkg::ST_LEN_LO;
                end
            slfp_pkg::ST_LEN_LO:
                if (accept)
                begin
                    state_next = slfp_pkg::ST_LEN_HI;
                end
            slfp_pkg::ST_LEN_HI:
                if (accept)
                begin
                    if (sts.len_over)
                    begin
                        state_next = slfp_pkg::ST_SYNC_A;
                    end
                    else if (sts.len_zero)
                    begin
                        state_next = slfp_pkg::ST_CHECK;
                    end
                    else
                    begin
                        state_next = slfp_pkg::ST_BODY;
                    end
                end
            slfp_pkg::ST_BODY:
                if (accept && sts.body_last)
                begin
                    state_next = slfp_pkg::ST_CHECK;
                end
            slfp_pkg::ST_CHECK:
                if (accept)
                begin
                    if (sts.crc_ok && !sts.len_empty)
                    begin
                        state_next = slfp_pkg::ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = slfp_pkg::ST_SYNC_A;
                    end
                end
            slfp_pkg::ST_EMIT_RD:
                state_next = slfp_pkg::ST_EMIT_WR;
            slfp_pkg::ST_EMIT_WR:
                if (sts.out_free)
                begin
                    state_next = sts.emit_last ? slfp_pkg::ST_SYNC_A : slfp_pkg::ST_EMIT_RD;
                end
            default:
                state_next = slfp_pkg::ST_SYNC_A;
        endcase
    end

endmodule

// ----- sv/sync_length_frame_parser_crc8_top.sv -----
// ============================================================================
// sync_length_frame_parser_crc8_top
// Sync/length/crc-8 frame parser: hunts two sync bytes, reads type, length,
// payload and crc, then delivers the frame or an error result.
// ============================================================================
//  channel  role    request payload
//  rx       sink    rx_byte
//  res      source  status, frame_type, frame_length, payload_byte,
//                   byte_index, last, resync_count
//  cfg      write   cfg_we / cfg_index / cfg_data
//
//  one received byte is taken per cycle while a frame is being read in
//  a good frame's payload is read out of the payload memory byte by byte
//  (registered memory read, then output register); no input is taken
//  during that burst
//  the length-high and crc bytes wait for a free output register
//  reset is immediate; the payload memory needs no clearing
module sync_length_frame_parser_crc8_top #(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    slfp_stream_if.sink                     rx,
    slfp_stream_if.source                   res,
    input  logic                            cfg_we,
    input  logic [slfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slfp_pkg::CFG_DATA_W-1:0] cfg_data
);
    slfp_pkg::cmd_t cmd;
    slfp_pkg::sts_t sts;
    slfp_pkg::rx_t  rx_item;
    slfp_pkg::res_t res_item;

    assign rx_item     = rx.payload;
    assign res.payload = res_item;

    slfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    slfp_datapath #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rx_byte     (rx_item.rx_byte),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (res.valid),
        .out_ready   (res.ready),
        .out_payload (res_item)
    );

endmodule

// ----- sim/tb_sync_length_frame_parser_crc8_top.sv -----
// ============================================================================
// tb_sync_length_frame_parser_crc8_top
// Self-checking bench for the sync/length/crc-8 frame parser. Byte streams of
// well-formed, corrupted, oversized and broken frames go in under several
// register settings. A local parser model predicts every result, and each
// delivered result is compared field by field in arrival order. Both channels
// idle at random, and the sink is held off once long enough to stall the input.
// ============================================================================
module tb_sync_length_frame_parser_crc8_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slfp_pkg::*;

    localparam int     CLK_HALF_NS   = 4;
    localparam int     RESET_CYCLES  = 5;
    localparam int     MEM_DEPTH     = 64;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     DRAIN_CYCLES  = 64;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     MAX_REPORTS   = 10;
    localparam longint TIMEOUT_NS    = 64'd16_000_000;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        GET_TYPE,
        GET_LEN_LO,
        GET_LEN_HI,
        GET_BODY,
        GET_CRC
    } parse_phase_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    slfp_stream_if #(.payload_t(rx_t))  rx_if ();
    slfp_stream_if #(.payload_t(res_t)) res_if ();

    sync_length_frame_parser_crc8_top #(
        .PAYLOAD_DEPTH(MEM_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_if),
        .res       (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // parser model state
    logic [DATA_W-1:0]    want_first;
    logic [DATA_W-1:0]    want_second;
    logic [LEN_W-1:0]     max_len_cfg;
    parse_phase_t         parse_phase;
    logic [DATA_W-1:0]    hdr_type;
    logic [HDR_LEN_W-1:0] hdr_length;
    logic [LEN_W-1:0]     body_count;
    logic [DATA_W-1:0]    crc_acc;
    logic [DATA_W-1:0]    body_mem [MEM_DEPTH];
    logic [CNT_W-1:0]     reject_total;

    res_t              results_due [$];
    logic [DATA_W-1:0] tx_bytes [$];

    int unsigned mismatch_count = 0;
    int unsigned bytes_queued   = 0;
    bit          rx_taken       = 1'b0;
    bit          hold_request   = 1'b0;
    bit          hold_sink      = 1'b0;
    int          tx_gap         = 0;
    int          tx_calm        = 0;
    int          sink_stall     = 0;
    int          sink_calm      = 0;

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] crc8_next(input logic [DATA_W-1:0] acc,
                                                    input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] v;
        v = acc ^ b;
        repeat (DATA_W)
        begin
            if ((v & CRC_MSB) != '0)
                v = (v << 1) ^ CRC_POLY;
            else
                v = v << 1;
        end
        return v;
    endfunction

    // mostly short gaps, a few long ones, now and then a stretch with none
    function automatic int pick_delay(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll == 0)
        begin
            calm = 40;
            return 0;
        end
        if (roll < 65)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic push_outcome(input logic [STATUS_W-1:0] st, input int len,
                                input logic [DATA_W-1:0] pb, input int idx, input bit fin);
        res_t r;
        r.status       = st;
        r.frame_type   = hdr_type;
        r.frame_length = len[LEN_W-1:0];
        r.payload_byte = pb;
        r.byte_index   = idx[IDX_W-1:0];
        r.last         = fin;
        r.resync_count = reject_total;
        results_due.push_back(r);
    endtask

    task automatic frame_restart();
        parse_phase = HUNT_FIRST;
        body_count  = '0;
        hdr_length  = '0;
    endtask

    task automatic parse_rx_byte(input logic [DATA_W-1:0] b);
        int cap;
        int n;
        case (parse_phase)
            HUNT_FIRST:
            begin
                if (b == want_first)
                    parse_phase = HUNT_SECOND;
            end
            HUNT_SECOND:
            begin
                // second sync wins over a repeated first sync
                if (b == want_second)
                begin
                    parse_phase = GET_TYPE;
                    crc_acc     = '0;
                end
                else if (b != want_first)
                    parse_phase = HUNT_FIRST;
            end
            GET_TYPE:
            begin
                hdr_type    = b;
                crc_acc     = crc8_next('0, b);
                parse_phase = GET_LEN_LO;
            end
            GET_LEN_LO:
            begin
                hdr_length  = {8'h00, b};
                crc_acc     = crc8_next(crc_acc, b);
                parse_phase = GET_LEN_HI;
            end
            GET_LEN_HI:
            begin
                hdr_length[15:8] = b;
                crc_acc          = crc8_next(crc_acc, b);
                cap              = (max_len_cfg > MEM_DEPTH) ? MEM_DEPTH : int'(max_len_cfg);
                if (hdr_length > cap)
                begin
                    reject_total++;
                    push_outcome(STATUS_LEN_ERR, 0, '0, 0, 1'b1);
                    frame_restart();
                end
                else
                begin
                    body_count  = '0;
                    parse_phase = (hdr_length != 0) ? GET_BODY : GET_CRC;
                end
            end
            GET_BODY:
            begin
                if (body_count < MEM_DEPTH)
                    body_mem[body_count[IDX_W-1:0]] = b;
                body_count++;
                crc_acc = crc8_next(crc_acc, b);
                if (body_count >= hdr_length)
                    parse_phase = GET_CRC;
            end
            GET_CRC:
            begin
                if (crc_acc != b)
                begin
                    reject_total++;
                    push_outcome(STATUS_CRC_ERR, 0, '0, 0, 1'b1);
                end
                else
                begin
                    n = (hdr_length > MEM_DEPTH) ? MEM_DEPTH : int'(hdr_length);
                    if (n == 0)
                        push_outcome(STATUS_GOOD, 0, '0, 0, 1'b1);
                    for (int i = 0; i < n; i++)
                        push_outcome(STATUS_GOOD, n, body_mem[i], i, i == n - 1);
                end
                frame_restart();
            end
            default:
                frame_restart();
        endcase
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (results_due.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: result with none outstanding: st=%0d type=%02h len=%0d",
                         $realtime, got.status, got.frame_type, got.frame_length);
        end
        else
        begin
            want = results_due.pop_front();
            if (got.status !== want.status || got.frame_type !== want.frame_type ||
                got.frame_length !== want.frame_length ||
                got.payload_byte !== want.payload_byte ||
                got.byte_index !== want.byte_index || got.last !== want.last ||
                got.resync_count !== want.resync_count)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected st=%0d type=%02h len=%0d byte=%02h idx=%0d",
                             want.status, want.frame_type, want.frame_length,
                             want.payload_byte, want.byte_index);
                    $display("           last=%0b rej=%0d", want.last, want.resync_count);
                    $display("  got      st=%0d type=%02h len=%0d byte=%02h idx=%0d",
                             got.status, got.frame_type, got.frame_length,
                             got.payload_byte, got.byte_index);
                    $display("           last=%0b rej=%0d", got.last, got.resync_count);
                end
            end
        end
    endtask

    // request monitor: results are checked before new bytes are predicted
    always @(posedge clk)
    begin
        rx_taken = rst_n && rx_if.valid && rx_if.ready;
        if (rst_n && res_if.valid && res_if.ready)
            check_result(res_if.payload);
        if (rx_taken)
            parse_rx_byte(rx_if.payload.rx_byte);
    end

    // byte sender
    always @(negedge clk)
    begin
        if (!rst_n)
            rx_if.valid <= 1'b0;
        else if (!rx_if.valid || rx_taken)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                rx_if.valid <= 1'b0;
            end
            else if (tx_bytes.size() != 0)
            begin
                rx_if.payload <= tx_bytes.pop_front();
                rx_if.valid   <= 1'b1;
                tx_gap = pick_delay(tx_calm);
            end
            else
                rx_if.valid <= 1'b0;
        end
    end

    // result sink
    always @(negedge clk)
    begin
        if (!rst_n || hold_sink)
            res_if.ready <= 1'b0;
        else if (sink_stall > 0)
        begin
            sink_stall--;
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= 1'b1;
            sink_stall = pick_delay(sink_calm);
        end
    end

    // long sink hold-off so the parser backs up into its input
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        hold_sink = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            CFG_SYNC_FIRST:   want_first  = value;
            CFG_SYNC_SECOND:  want_second = value;
            CFG_LENGTH_LIMIT: max_len_cfg = value[LEN_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic push_byte(input logic [DATA_W-1:0] b);
        tx_bytes.push_back(b);
        bytes_queued++;
    endtask

    // header, body and trailing crc; corrupt flips crc bits
    task automatic push_frame(input logic [DATA_W-1:0] ftype, input logic [HDR_LEN_W-1:0] len,
                              input int body, input bit corrupt);
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] flip;
        push_byte(want_first);
        push_byte(want_second);
        push_byte(ftype);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        acc = crc8_next('0, ftype);
        acc = crc8_next(acc, len[7:0]);
        acc = crc8_next(acc, len[15:8]);
        for (int i = 0; i < body; i++)
        begin
            case ($urandom_range(9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            push_byte(b);
            acc = crc8_next(acc, b);
        end
        flip = 8'($urandom_range(1, 255));
        push_byte(corrupt ? (acc ^ flip) : acc);
    endtask

    function automatic int pick_length(input int cap);
        if (cap == 0)
            return 0;
        if ($urandom_range(9) != 0)
            return $urandom_range(0, (cap < 6) ? cap : 6);
        return $urandom_range(0, cap);
    endfunction

    task automatic queue_random_traffic(input int unsigned target);
        int                   cap;
        int                   roll;
        int                   len;
        logic [HDR_LEN_W-1:0] big;
        cap = (max_len_cfg > MEM_DEPTH) ? MEM_DEPTH : int'(max_len_cfg);
        while (bytes_queued < target)
        begin
            roll = $urandom_range(99);
            if (roll < 65)
            begin
                len = pick_length(cap);
                push_frame(8'($urandom), len[HDR_LEN_W-1:0], len, 1'b0);
            end
            else if (roll < 77)
            begin
                len = pick_length(cap);
                push_frame(8'($urandom), len[HDR_LEN_W-1:0], len, 1'b1);
            end
            else if (roll < 85)
            begin
                // oversized length, the rest of the frame is junk
                if ($urandom_range(1) != 0)
                    big = 16'(cap + 1 + int'($urandom_range(0, 7)));
                else
                    big = 16'($urandom_range(cap + 1, 16'hFFFF));
                push_frame(8'($urandom), big, $urandom_range(0, 3), 1'b0);
            end
            else if (roll < 92)
            begin
                repeat ($urandom_range(1, 5))
                    push_byte(8'($urandom));
            end
            else
            begin
                // sync run that breaks off
                push_byte(want_first);
                repeat ($urandom_range(0, 2))
                    push_byte(want_first);
                push_byte(8'($urandom));
            end
        end
    endtask

    // everything sent and answered, then let the parser settle
    task automatic wait_idle();
        while (tx_bytes.size() != 0 || rx_if.valid || results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.payload = '0;
        res_if.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SYNC_FIRST;
        cfg_data      = '0;
        want_first    = SYNC_FIRST_RST;
        want_second   = SYNC_SECOND_RST;
        max_len_cfg   = LENGTH_LIMIT_RST;
        parse_phase   = HUNT_FIRST;
        hdr_type      = '0;
        hdr_length    = '0;
        body_count    = '0;
        crc_acc       = '0;
        reject_total  = '0;
        for (int i = 0; i < MEM_DEPTH; i++)
            body_mem[i] = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: empty frame, repeated first sync, oversized, bad crc
        push_frame(8'h00, 16'h0000, 0, 1'b0);
        push_byte(want_first);
        push_frame(8'hFF, 16'h0001, 1, 1'b0);
        push_frame(8'h3C, 16'h0100, 0, 1'b0);
        push_frame(8'hA5, 16'h0002, 2, 1'b1);
        wait_idle();

        // both sync bytes equal, only empty frames fit
        write_reg(CFG_SYNC_FIRST, 8'h7E);
        write_reg(CFG_SYNC_SECOND, 8'h7E);
        write_reg(CFG_LENGTH_LIMIT, 8'h00);
        push_frame(8'h11, 16'h0001, 1, 1'b0);
        queue_random_traffic(bytes_queued + 40);
        wait_idle();

        // limit above the memory depth, plus the long sink hold-off
        write_reg(CFG_LENGTH_LIMIT, 8'hFF);
        write_reg(CFG_SYNC_FIRST, 8'h00);
        write_reg(CFG_SYNC_SECOND, 8'hFF);
        write_reg(CFG_SPARE, 8'($urandom));
        push_frame(8'($urandom), 16'(MEM_DEPTH), MEM_DEPTH, 1'b0);
        push_frame(8'($urandom), 16'(MEM_DEPTH + 1), 0, 1'b0);
        hold_request = 1'b1;
        push_frame(8'($urandom), 16'(MEM_DEPTH), MEM_DEPTH, 1'b0);
        queue_random_traffic(bytes_queued + 40);
        wait_idle();

        write_reg(CFG_SYNC_FIRST, SYNC_FIRST_RST);
        write_reg(CFG_SYNC_SECOND, SYNC_SECOND_RST);
        write_reg(CFG_LENGTH_LIMIT, 8'(MEM_DEPTH));
        queue_random_traffic(bytes_queued + 100);
        wait_idle();

        repeat (2)
        begin
            write_reg(CFG_SYNC_FIRST, 8'($urandom));
            write_reg(CFG_SYNC_SECOND, 8'($urandom));
            write_reg(CFG_LENGTH_LIMIT, 8'($urandom_range(1, 255)));
            write_reg(CFG_SPARE, 8'($urandom));
            queue_random_traffic(bytes_queued + 50);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sync_length_frame_parser_crc8_top.f -----
sv/slfp_pkg.sv
sv/slfp_stream_if.sv
sv/slfp_datapath.sv
sv/slfp_ctrl.sv
sv/sync_length_frame_parser_crc8_top.sv
sim/tb_sync_length_frame_parser_crc8_top.sv
